// ----- rtl/core/first_fit_extent_allocator_unit_macros.svh -----
// Shared assertion macros for the allocator.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_MACROS_SVH

// check outside reset
`define FFA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffa assertion failed");

// check at every edge, reset included
`define FFA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ffa assertion failed");

`endif

// ----- rtl/core/ffa_pkg.sv -----
package ffa_pkg;

   localparam int unsigned POOL_UNITS  = 4096;
   localparam int unsigned MAX_EXTENTS = 64;
   localparam int unsigned ADDR_W      = 12;
   localparam int unsigned LEN_W       = 13;
   localparam int unsigned IDX_W       = $clog2(MAX_EXTENTS);
   localparam int unsigned CNT_W       = IDX_W + 1;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_MERGE_RD,
      S_MERGE_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR
   } state_type;

   typedef enum logic [0:0] {
      GROW_DOWN = 1'b0,
      GROW_UP   = 1'b1
   } grow_type;

   typedef struct packed {
      op_type             opcode;
      logic [LEN_W-1:0]   request_size;
      logic [ADDR_W-1:0]  free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [LEN_W-1:0]   length;
   } ent_type;

endpackage

// ----- rtl/core/ffa_ram.sv -----
module ffa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/first_fit_extent_allocator_unit.sv -----
// Channel    Ports                         Transfer
// request    start, busy, req_data         start high while busy low
// response   rsp_valid, rsp_data           one-cycle strobe, no backpressure
//
// An allocate reads the extent table one entry at a time until the first fit,
// then shifts the later entries down, one by one, when the extent empties.
// A free scans for a neighbor, appending a new extent if none abuts, or scans again
// for a merge partner and may shift; the single table RAM port pair paces each step.
// After reset, S_INIT writes the initial extent; busy stays high meanwhile.
// The receiver cannot stall: every transaction gives one response strobe.
module first_fit_extent_allocator_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ffa_pkg::req_type req_data,
   output logic            rsp_valid,
   output ffa_pkg::rsp_type rsp_data
);
   import ffa_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     hit_ff, hit_in;
   grow_type             mode_ff, mode_in;
   req_type              req_ff, req_in;
   logic [ADDR_W-1:0]    ns_ff, ns_in;
   logic [LEN_W-1:0]     nl_ff, nl_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   ent_type              wr_data, rd_data;

   logic [LEN_W:0]       free_end;
   logic [LEN_W-1:0]     rd_end;
   logic [LEN_W-1:0]     new_end;
   logic [CNT_W-1:0]     idx_next;

   ffa_ram #(
      .WIDTH($bits(ent_type)),
      .DEPTH(MAX_EXTENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign free_end = (LEN_W+1)'(req_ff.request_size) + (LEN_W+1)'(req_ff.free_address);
   assign rd_end   = LEN_W'(rd_data.start) + rd_data.length;
   assign new_end  = LEN_W'(ns_ff) + nl_ff;
   assign idx_next = idx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      hit_ff  <= hit_in;
      mode_ff <= mode_in;
      req_ff  <= req_in;
      ns_ff   <= ns_in;
      nl_ff   <= nl_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      mode_in      = mode_ff;
      req_in       = req_ff;
      ns_in        = ns_ff;
      nl_in        = nl_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data.start  = '0;
            wr_data.length = LEN_W'(POOL_UNITS);
            state_in       = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in         = req_data;
               idx_in         = '0;
               rsp_in.address = '0;
               rsp_in.status  = ST_OK;
               state_in       = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (req_ff.opcode == OP_FREE && (req_ff.request_size == '0 ||
                free_end > (LEN_W+1)'(POOL_UNITS))) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (idx_ff == count_ff) begin
               if (req_ff.opcode == OP_ALLOC) begin
                  rsp_in.status = ST_NOFIT;
               end else if (count_ff >= CNT_W'(MAX_EXTENTS)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  wr_en          = 1'b1;
                  wr_data.start  = req_ff.free_address;
                  wr_data.length = req_ff.request_size;
                  count_in       = idx_next;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            hit_in = idx_ff[IDX_W-1:0];
            if (req_ff.opcode == OP_ALLOC) begin
               if (rd_data.length >= req_ff.request_size) begin
                  rsp_in.address = rd_data.start;
                  if (req_ff.request_size == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else if (rd_data.length == req_ff.request_size) begin
                     state_in = S_SHIFT_RD;
                  end else begin
                     wr_en          = 1'b1;
                     wr_data.start  = rd_data.start + req_ff.request_size[ADDR_W-1:0];
                     wr_data.length = rd_data.length - req_ff.request_size;
                     rsp_valid_in   = 1'b1;
                     state_in       = S_IDLE;
                  end
               end else begin
                  idx_in   = idx_next;
                  state_in = S_SCAN_RD;
               end
            end else begin
               if ((LEN_W+1)'(rd_data.start) == free_end) begin
                  mode_in        = GROW_DOWN;
                  ns_in          = req_ff.free_address;
                  nl_in          = rd_data.length + req_ff.request_size;
                  wr_en          = 1'b1;
                  wr_data.start  = req_ff.free_address;
                  wr_data.length = rd_data.length + req_ff.request_size;
                  idx_in         = '0;
                  state_in       = S_MERGE_RD;
               end else if (rd_end == LEN_W'(req_ff.free_address)) begin
                  mode_in        = GROW_UP;
                  ns_in          = rd_data.start;
                  nl_in          = rd_data.length + req_ff.request_size;
                  wr_en          = 1'b1;
                  wr_data.start  = rd_data.start;
                  wr_data.length = rd_data.length + req_ff.request_size;
                  idx_in         = '0;
                  state_in       = S_MERGE_RD;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_MERGE_RD: begin
            if (idx_ff == count_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (idx_ff == CNT_W'(hit_ff)) begin
               idx_in = idx_next;
            end else begin
               rd_en    = 1'b1;
               state_in = S_MERGE_CHK;
            end
         end
         S_MERGE_CHK: begin
            if (mode_ff == GROW_DOWN && rd_end == LEN_W'(ns_ff)) begin
               wr_en          = 1'b1;
               wr_data.start  = rd_data.start;
               wr_data.length = rd_data.length + nl_ff;
               idx_in         = CNT_W'(hit_ff);
               state_in       = S_SHIFT_RD;
            end else if (mode_ff == GROW_UP && LEN_W'(rd_data.start) == new_end) begin
               wr_en          = 1'b1;
               wr_data.start  = ns_ff;
               wr_data.length = rd_data.length + nl_ff;
               idx_in         = CNT_W'(hit_ff);
               state_in       = S_SHIFT_RD;
            end else begin
               idx_in   = idx_next;
               state_in = S_MERGE_RD;
            end
         end
         S_SHIFT_RD: begin
            if (idx_next >= count_ff) begin
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_next[IDX_W-1:0];
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_next;
            state_in = S_SHIFT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/ffa_checker.sv -----
`include "first_fit_extent_allocator_unit_macros.svh"

module ffa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input ffa_pkg::req_type req_data,
   input logic             rsp_valid,
   input ffa_pkg::rsp_type rsp_data
);
   import ffa_pkg::*;

   logic accepted;
   assign accepted = start && !busy;

   `FFA_ASSERT(a_accept_progress, clock, reset, accepted |=> (busy || rsp_valid))
   `FFA_ASSERT(a_error_addr_zero, clock, reset,
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.address == '0))
   `FFA_ASSERT(a_status_legal, clock, reset, rsp_valid |-> (rsp_data.status != 2'd3))
   `FFA_ASSERT(a_free_addr_zero, clock, reset,
      (accepted && req_data.opcode == OP_FREE) |=> (busy || rsp_data.address == '0))
   `FFA_ASSERT_ALWAYS(a_reset_busy, clock, reset |=> (busy && !rsp_valid))

endmodule

bind first_fit_extent_allocator_unit ffa_checker u_ffa_checker (.*);
